>>> hdl/ccs_pkg.sv
// Shared types and character codes for the C comment stripper.
`default_nettype none

package ccs_pkg;

	typedef enum logic [3:0] {
		M_NORMAL     = 4'd0,
		M_SLASH      = 4'd1,
		M_BLOCK      = 4'd2,
		M_BLOCK_STAR = 4'd3,
		M_LINE       = 4'd4,
		M_LINE_BS    = 4'd5,
		M_LINE_BS_CR = 4'd6,
		M_QUOTE      = 4'd7,
		M_QUOTE_BS   = 4'd8,
		M_QUOTE_BSCR = 4'd9
	} mode_t;

	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
	} scan_res_t;

endpackage

`default_nettype wire

>>> hdl/ccs_scan.sv
// Per-byte scanner transition: next mode and the results one byte causes.
`default_nettype none

module ccs_scan
	import ccs_pkg::*;
(
	input  mode_t      mode,
	input  logic       dq,
	input  logic [7:0] in_byte,
	input  logic       end_of_stream,
	output mode_t      mode_nxt,
	output logic       dq_nxt,
	output scan_res_t  res
);

	typedef struct packed {
		mode_t      mode;
		logic       dq;
		logic       emit;
		logic [7:0] val;
	} step_t;

	function automatic step_t normal_step(input logic [7:0] c, input logic d);
		step_t s;
		s.mode = M_NORMAL;
		s.dq   = d;
		s.emit = 1'b1;
		s.val  = c;
		if (c == CH_DQ || c == CH_SQ) begin
			s.dq   = (c == CH_DQ);
			s.mode = M_QUOTE;
		end else if (c == CH_SLASH) begin
			s.mode = M_SLASH;
			s.emit = 1'b0;
		end
		return s;
	endfunction

	function automatic step_t line_step(input logic [7:0] c, input logic d);
		step_t s;
		s.mode = M_LINE;
		s.dq   = d;
		s.emit = 1'b0;
		s.val  = CH_LF;
		if (c == CH_LF || c == CH_NUL) begin
			s.emit = 1'b1;
			s.mode = M_NORMAL;
		end else if (c == CH_BSL) begin
			s.mode = M_LINE_BS;
		end
		return s;
	endfunction

	function automatic step_t quote_step(input logic [7:0] c, input logic d);
		step_t s;
		s.mode = M_QUOTE;
		s.dq   = d;
		s.emit = 1'b1;
		s.val  = c;
		if (c == (d ? CH_DQ : CH_SQ) || c == CH_LF || c == CH_NUL) begin
			s.mode = M_NORMAL;
		end else if (c == CH_BSL) begin
			s.mode = M_QUOTE_BS;
		end
		return s;
	endfunction

	step_t      st;
	logic       pre;
	logic       tail;
	logic [7:0] tail_v;

	always_comb begin
		pre     = 1'b0;
		st.mode = mode;
		st.dq   = dq;
		st.emit = 1'b0;
		st.val  = in_byte;
		unique case (mode)
			M_SLASH: begin
				if (in_byte == CH_STAR) begin
					st.mode = M_BLOCK;
				end else if (in_byte == CH_SLASH) begin
					st.mode = M_LINE;
				end else begin
					pre = 1'b1;
					st  = normal_step(in_byte, dq);
				end
			end
			M_BLOCK: begin
				st.mode = (in_byte == CH_STAR) ? M_BLOCK_STAR : M_BLOCK;
			end
			M_BLOCK_STAR: begin
				if (in_byte == CH_SLASH) begin
					st.emit = 1'b1;
					st.val  = CH_LF;
					st.mode = M_NORMAL;
				end else if (in_byte != CH_STAR) begin
					st.mode = M_BLOCK;
				end
			end
			M_LINE: begin
				st = line_step(in_byte, dq);
			end
			M_LINE_BS: begin
				if (in_byte == CH_LF) begin
					st.mode = M_LINE;
				end else if (in_byte == CH_CR) begin
					st.mode = M_LINE_BS_CR;
				end else begin
					st = line_step(in_byte, dq);
				end
			end
			M_LINE_BS_CR: begin
				if (in_byte == CH_LF) begin
					st.mode = M_LINE;
				end else begin
					st = line_step(in_byte, dq);
				end
			end
			M_QUOTE: begin
				st = quote_step(in_byte, dq);
			end
			M_QUOTE_BS: begin
				st.emit = 1'b1;
				st.mode = (in_byte == CH_CR) ? M_QUOTE_BSCR : M_QUOTE;
			end
			M_QUOTE_BSCR: begin
				if (in_byte == CH_LF) begin
					st.emit = 1'b1;
					st.mode = M_QUOTE;
				end else begin
					st = quote_step(in_byte, dq);
				end
			end
			default: begin
				st = normal_step(in_byte, dq);
			end
		endcase
	end

	always_comb begin
		tail     = 1'b0;
		tail_v   = CH_LF;
		mode_nxt = st.mode;
		dq_nxt   = st.dq;
		if (end_of_stream) begin
			if (st.mode == M_SLASH) begin
				tail   = 1'b1;
				tail_v = CH_SLASH;
			end else if (st.mode == M_BLOCK || st.mode == M_BLOCK_STAR ||
			             st.mode == M_LINE || st.mode == M_LINE_BS ||
			             st.mode == M_LINE_BS_CR) begin
				tail = 1'b1;
			end
			mode_nxt = M_NORMAL;
			dq_nxt   = 1'b0;
		end
	end

	always_comb begin
		res.cnt = 2'd0;
		res.b0  = tail_v;
		res.b1  = tail_v;
		if (pre) begin
			res.b0  = CH_SLASH;
			res.cnt = (st.emit || tail) ? 2'd2 : 2'd1;
			if (st.emit) begin
				res.b1 = st.val;
			end
		end else if (st.emit) begin
			res.b0  = st.val;
			res.cnt = tail ? 2'd2 : 2'd1;
		end else if (tail) begin
			res.cnt = 2'd1;
		end
	end

endmodule

`default_nettype wire

>>> hdl/ccs_res_fifo.sv
// Result queue: takes up to two results per cycle, delivers one per transfer.
`default_nettype none

module ccs_res_fifo
	import ccs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  scan_res_t  res,
	output logic       room,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_byte,
	output logic       run_last
);

	logic [7:0]         data_q [FIFO_DEPTH];
	logic               last_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;
	logic [FIFO_AW-1:0] wr_nxt;
	logic [1:0]         n_push;
	logic               pop;

	assign wr_nxt    = wr_q + FIFO_AW'(1);
	assign n_push    = push ? res.cnt : 2'd0;
	assign pop       = res_valid && !res_stall;
	assign res_valid = (cnt_q != '0);
	assign room      = (cnt_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
	assign out_byte  = data_q[rd_q];
	assign run_last  = last_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + FIFO_AW'(n_push);
			if (pop) begin
				rd_q <= rd_q + FIFO_AW'(1);
			end
			cnt_q <= cnt_q + (FIFO_AW + 1)'(n_push) - (FIFO_AW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			data_q[wr_q] <= res.b0;
			last_q[wr_q] <= (n_push == 2'd1);
		end
		if (n_push == 2'd2) begin
			data_q[wr_nxt] <= res.b1;
			last_q[wr_nxt] <= 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> hdl/c_comment_stripper_unit.sv
// Top level of the C comment stripper: input register, scanner state, result queue.
//
// Usage:
//   Source bytes enter on the byte channel (byte_valid, byte_stall, in_byte,
//   end_of_stream); end_of_stream marks the final byte of a source stream.
//   Comment-free text leaves on the result channel (res_valid, res_stall,
//   out_byte, run_last); run_last marks the last result a source byte causes.
//   A byte causes zero, one or two results.
//   A transferred byte waits in the input register, is scanned combinationally
//   and its results enter the result queue that drives the result channel.
//   Throughput: one byte per cycle while the result queue has room; the result
//   channel moves one result per cycle while res_stall is low.
//   The scanner mode is one register updated by a single transition per byte.
//   Reset clears the scanner to normal text and empties the result queue.
//   When the receiver stalls, results wait in a four-entry queue; once fewer
//   than two slots are free the input register holds and byte_stall rises.
//   After the final byte of a stream the scanner returns to normal text.
`default_nettype none

module c_comment_stripper_unit
	import ccs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_stream,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_byte,
	output logic       run_last
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	mode_t      mode_q;
	logic       dq_q;
	mode_t      mode_nxt;
	logic       dq_nxt;
	scan_res_t  res;
	logic       room;
	logic       advance;
	logic       accept;

	assign advance    = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= M_NORMAL;
			dq_q     <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				mode_q <= mode_nxt;
				dq_q   <= dq_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			eos_s1  <= end_of_stream;
		end
	end

	ccs_scan u_scan (
		.mode          (mode_q),
		.dq            (dq_q),
		.in_byte       (byte_s1),
		.end_of_stream (eos_s1),
		.mode_nxt      (mode_nxt),
		.dq_nxt        (dq_nxt),
		.res           (res)
	);

	ccs_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.res       (res),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule

`default_nettype wire

>>> hdl/ccs_checker.sv
// Port-level checks for the C comment stripper, bound to the top level.
`default_nettype none

module ccs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       byte_valid,
	input logic       byte_stall,
	input logic [7:0] in_byte,
	input logic       end_of_stream,
	input logic       res_valid,
	input logic       res_stall,
	input logic [7:0] out_byte,
	input logic       run_last
);

	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=>
			byte_valid && $stable(in_byte) && $stable(end_of_stream))
		else $error("stalled source byte changed");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_byte) && $stable(run_last))
		else $error("stalled result changed");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !run_last |=> res_valid && run_last)
		else $error("first result of a pair not followed by its last result");

	a_stall_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> res_valid)
		else $error("input stalled with no result pending");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !res_valid && !byte_stall)
		else $error("result or stall shown during reset");

endmodule

bind c_comment_stripper_unit ccs_checker u_ccs_checker (.*);

`default_nettype wire
